[sv/bmpgg_pkg.sv]
// Package for the BMP grey/glyph stream block: codes, field widths and constant tables.
`default_nettype none
package bmpgg_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int HEADER_BYTES = 54;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SIG     = 3'd1,
		ERR_DEPTH   = 3'd2,
		ERR_COMPR   = 3'd3,
		ERR_SIZE    = 3'd4
	} err_code_t;

	// header byte positions that matter
	localparam logic [5:0] POS_SIG    = 6'd1;
	localparam logic [5:0] POS_WIDTH  = 6'd21;
	localparam logic [5:0] POS_HEIGHT = 6'd25;
	localparam logic [5:0] POS_BPP    = 6'd28;
	localparam logic [5:0] POS_COMPR  = 6'd33;
	localparam logic [5:0] POS_END    = 6'(HEADER_BYTES - 1);

	localparam logic [15:0] BMP_SIG = 16'h4D42;
	localparam logic [7:0]  BPP_24  = 8'd24;

	// luminance weights, Q0.16
	localparam logic [15:0] W_RED   = 16'd13937;
	localparam logic [15:0] W_GREEN = 16'd46869;
	localparam logic [15:0] W_BLUE  = 16'd4731;

	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned DEN     = 64'd510;
	localparam longint unsigned QDIV    = 64'd1055 * DEN;
	localparam longint unsigned LDIV    = 64'd1292 * DEN;

	// 65-character ramp, first character in the top byte
	localparam logic [65*8-1:0] RAMP =
		"`^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

	typedef logic [15:0] lin_rom_t [256];
	typedef logic [15:0] bound_rom_t [255];
	typedef logic [6:0]  glyph_rom_t [256];

	function automatic longint unsigned fifth_q30(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int i = 0; i < 4; i++) p = (p * r) >> 30;
		return p;
	endfunction

	// linear light in Q0.16 for the code num/510
	function automatic logic [15:0] srgb_lin(longint unsigned num);
		longint unsigned x, s, lo, hi, mid, lin;
		if (num * 64'd100000 <= 64'd4045 * DEN)
			return 16'((num * 64'd6553600 + 64'd646 * DEN) / LDIV);
		x = (((64'd1000 * num + 64'd55 * DEN) << 30) + QDIV / 2) / QDIV;
		if (x > Q30_ONE) x = Q30_ONE;
		s = (x * x + (Q30_ONE >> 1)) >> 30;
		lo = 0;
		hi = Q30_ONE;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (fifth_q30(mid) <= s) lo = mid;
			else hi = mid - 1;
		end
		lin = (s * lo + (Q30_ONE >> 1)) >> 30;
		lin = (lin + 64'd8192) >> 14;
		return (lin > 64'd65535) ? 16'hFFFF : 16'(lin);
	endfunction

	function automatic lin_rom_t build_lin();
		lin_rom_t t;
		for (int k = 0; k < 256; k++) t[k] = srgb_lin(longint'(2 * k));
		return t;
	endfunction

	function automatic bound_rom_t build_bound();
		bound_rom_t t;
		for (int k = 0; k < 255; k++) t[k] = srgb_lin(longint'(2 * k + 1));
		return t;
	endfunction

	function automatic glyph_rom_t build_glyph();
		glyph_rom_t t;
		int idx;
		for (int g = 0; g < 256; g++) begin
			idx = (g * 64) / 255;
			t[g] = RAMP[(64 - idx) * 8 +: 7];
		end
		return t;
	endfunction

	localparam lin_rom_t   LIN_ROM   = build_lin();
	localparam bound_rom_t BOUND_ROM = build_bound();
	localparam glyph_rom_t GLYPH_ROM = build_glyph();

endpackage
`default_nettype wire

[sv/bmp24_stream_to_grey_glyph_top.sv]
// BMP 24-bit byte stream parser with sRGB luminance and ramp glyph output.
// Path: a pixel result passes the parse, lookup/multiply, sum and search/output registers after
// its red byte is taken; errors follow the same path.
// Throughput: one byte per cycle, three bytes per pixel; a stalled output stalls the pipe.
// Reset: arst_n clears parser state and pipeline valids; the first byte is header byte 0.
`default_nettype none
module bmp24_stream_to_grey_glyph_top import bmpgg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] file_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [2:0] error_code, [10:3] grey, [17:11] glyph,
	                                         // [29:18] row, [41:30] column, rest zero
	output logic             m_axis_tuser,   // [0] kind
	output logic             m_axis_tlast    // last
);

	typedef enum logic [1:0] {PH_HEADER, PH_PIXELS, PH_PAD, PH_HALT} phase_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  code;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
	} tag_t;

	phase_t      phase_q;
	logic [5:0]  hpos_q;
	logic [31:0] raw_q;
	logic [12:0] width_q, height_q;
	logic        td_q;
	logic [11:0] rowc_q, colc_q;
	logic [1:0]  chan_q, pad_q;
	logic [7:0]  blue_q, green_q;

	logic adv, take;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign take = s_axis_tvalid && adv;

	// parser next state
	phase_t      ph, ph_n;
	logic [5:0]  hp, hp_n;
	logic [31:0] rw, rw_n, mag;
	logic [12:0] wd, wd_n, ht, ht_n;
	logic        td, td_n;
	logic [11:0] rc, rc_n, cc, cc_n;
	logic [1:0]  ch, ch_n, pd, pd_n;
	logic [7:0]  bl, bl_n, gr, gr_n, b;
	logic        emit;
	tag_t        tag;

	always_comb begin
		b = s_axis_tdata;
		ph = phase_q; hp = hpos_q; rw = raw_q; wd = width_q; ht = height_q; td = td_q;
		rc = rowc_q; cc = colc_q; ch = chan_q; pd = pad_q; bl = blue_q; gr = green_q;
		if (s_axis_tuser) begin
			ph = PH_HEADER; hp = '0; rw = '0; wd = '0; ht = '0; td = 1'b0;
			rc = '0; cc = '0; ch = '0; pd = '0; bl = '0; gr = '0;
		end
		ph_n = ph; hp_n = hp; rw_n = rw; wd_n = wd; ht_n = ht; td_n = td;
		rc_n = rc; cc_n = cc; ch_n = ch; pd_n = pd; bl_n = bl; gr_n = gr;
		emit = 1'b0;
		mag = '0;
		tag = '0;
		case (ph)
			PH_HEADER: begin
				rw_n = {b, rw[31:8]};
				hp_n = hp + 6'd1;
				if (hp == POS_SIG) begin
					if (rw_n[31:16] != BMP_SIG) begin emit = 1'b1; tag.code = ERR_SIG; end
				end else if (hp == POS_WIDTH) begin
					wd_n = (rw_n >= 32'd1 && rw_n <= 32'(MAX_WIDTH)) ? rw_n[12:0] : '0;
				end else if (hp == POS_HEIGHT) begin
					td_n = rw_n[31];
					mag = rw_n[31] ? (~rw_n + 32'd1) : rw_n;
					ht_n = (mag >= 32'd1 && mag <= 32'(MAX_HEIGHT)) ? mag[12:0] : '0;
				end else if (hp == POS_BPP) begin
					if (b != BPP_24) begin emit = 1'b1; tag.code = ERR_DEPTH; end
				end else if (hp == POS_COMPR) begin
					if (rw_n != '0) begin emit = 1'b1; tag.code = ERR_COMPR; end
				end else if (hp == POS_END) begin
					if (wd == '0 || ht == '0) begin
						emit = 1'b1; tag.code = ERR_SIZE;
					end else begin
						ph_n = PH_PIXELS; rc_n = '0; cc_n = '0; ch_n = '0;
					end
				end else if (hp > POS_END) begin
					ph_n = PH_HALT;
				end
				if (emit) begin
					tag.kind = 1'b1;
					ph_n = PH_HALT;
				end
			end
			PH_PIXELS: begin
				if (ch == 2'd0) begin
					bl_n = b; ch_n = 2'd1;
				end else if (ch == 2'd1) begin
					gr_n = b; ch_n = 2'd2;
				end else begin
					ch_n = 2'd0;
					emit = 1'b1;
					tag.row = td ? rc : 12'(ht - 13'd1 - {1'b0, rc});
					tag.col = cc;
					if ({1'b0, cc} + 13'd1 >= wd) begin
						cc_n = '0;
						if ({1'b0, rc} + 13'd1 >= ht) begin
							tag.last = 1'b1;
							ph_n = PH_HALT;
						end else begin
							rc_n = rc + 12'd1;
							pd_n = wd[1:0];
							if (wd[1:0] != 2'd0) ph_n = PH_PAD;
						end
					end else begin
						cc_n = cc + 12'd1;
					end
				end
			end
			PH_PAD: begin
				pd_n = pd - 2'd1;
				if (pd_n == 2'd0) ph_n = PH_PIXELS;
			end
			default: ;
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hpos_q <= '0; raw_q <= '0; width_q <= '0; height_q <= '0;
			td_q <= 1'b0; rowc_q <= '0; colc_q <= '0; chan_q <= '0; pad_q <= '0;
			blue_q <= '0; green_q <= '0;
		end else if (take) begin
			phase_q <= ph_n; hpos_q <= hp_n; raw_q <= rw_n; width_q <= wd_n; height_q <= ht_n;
			td_q <= td_n; rowc_q <= rc_n; colc_q <= cc_n; chan_q <= ch_n; pad_q <= pd_n;
			blue_q <= bl_n; green_q <= gr_n;
		end
	end

	// pipeline: s1 parsed item, s2 products, s3 luminance, then output register
	logic        v_s1, v_s2, v_s3;
	tag_t        tag_s1, tag_s2, tag_s3;
	logic [7:0]  b_s1, g_s1, r_s1;
	logic [31:0] pr_s2, pg_s2, pb_s2;
	logic [15:0] y_s3;
	logic [32:0] ysum;
	logic [16:0] ysh;
	logic [7:0]  grey_c, idx;

	assign ysum = {1'b0, pr_s2} + {1'b0, pg_s2} + {1'b0, pb_s2} + 33'd32768;
	assign ysh  = ysum[32:16];

	// count of boundaries at or below Y, by binary search over the sorted table
	always_comb begin
		grey_c = '0;
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			idx = grey_c + 8'((1 << i) - 1);
			if (BOUND_ROM[idx] <= y_s3) grey_c = grey_c + 8'(1 << i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= take && emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag; b_s1 <= bl; g_s1 <= gr; r_s1 <= b;
			tag_s2 <= tag_s1;
			pr_s2 <= 32'(W_RED) * 32'(LIN_ROM[r_s1]);
			pg_s2 <= 32'(W_GREEN) * 32'(LIN_ROM[g_s1]);
			pb_s2 <= 32'(W_BLUE) * 32'(LIN_ROM[b_s1]);
			tag_s3 <= tag_s2;
			y_s3 <= ysh[16] ? 16'hFFFF : ysh[15:0];
			m_axis_tuser <= tag_s3.kind;
			m_axis_tlast <= tag_s3.last;
			m_axis_tdata <= {6'd0, tag_s3.col, tag_s3.row,
				tag_s3.kind ? 7'd0 : GLYPH_ROM[grey_c],
				tag_s3.kind ? 8'd0 : grey_c, tag_s3.code};
		end
	end

	// checks
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[41:3] == '0 && !m_axis_tlast)
		else $error("error item carries pixel fields");
	a_pix_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2:0] == ERR_NONE)
		else $error("pixel item carries an error code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output item changed");

endmodule
`default_nettype wire

[sim/bmp24_stream_to_grey_glyph_top_tb.sv]
// Testbench for the BMP grey/glyph stream block: random BMP byte streams against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module bmp24_stream_to_grey_glyph_top_tb import bmpgg_pkg::*; ();

	typedef struct packed {
		logic        kind;
		logic [2:0]  code;
		logic [7:0]  grey;
		logic [6:0]  glyph;
		logic [11:0] row;
		logic [11:0] column;
		logic        last;
	} pixel_res_t;

	localparam int IDLE_LIMIT = 20000;
	localparam string RAMP_STR =
		"`^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

	// predictor tables built independently from the sRGB transfer definition
	longint unsigned lin_lut [256];
	longint unsigned enc_lut [255];

	function automatic longint unsigned pow5_q30(longint unsigned r);
		longint unsigned p;
		p = r;
		repeat (4) p = (p * r) >> 30;
		return p;
	endfunction

	function automatic longint unsigned decode_lin(longint unsigned num, longint unsigned den);
		longint unsigned q, x, s, lo, hi, mid, l;
		if (num * 100000 <= 4045 * den)
			return (num * 6553600 + 646 * den) / (1292 * den);
		q = 1055 * den;
		x = (((1000 * num + 55 * den) << 30) + q / 2) / q;
		if (x > 64'd1073741824) x = 64'd1073741824;
		s = (x * x + 64'd536870912) >> 30;
		lo = 0;
		hi = 64'd1073741824;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (pow5_q30(mid) <= s) lo = mid;
			else hi = mid - 1;
		end
		l = (s * lo + 64'd536870912) >> 30;
		l = (l + 8192) >> 14;
		return (l > 65535) ? 65535 : l;
	endfunction

	// scoreboard: parse state mirror and queue of pending pixel/error results
	class bmp_scoreboard;
		int unsigned phase, hpos, raw, wid, hgt, tdown, rcnt, ccnt, chan, bl, gr, padl;
		pixel_res_t pending[$];
		int errors;

		function void clear_parse();
			phase = 0; hpos = 0; raw = 0; wid = 0; hgt = 0; tdown = 0;
			rcnt = 0; ccnt = 0; chan = 0; bl = 0; gr = 0; padl = 0;
		endfunction

		function pixel_res_t make_err(err_code_t c);
			pixel_res_t r;
			r = '0;
			r.kind = 1'b1;
			r.code = c;
			phase = 3;
			return r;
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			int unsigned p, mag, y, g;
			pixel_res_t r;
			if (start) clear_parse();
			case (phase)
			0: begin
				p = hpos;
				raw = (raw >> 8) | (32'(b) << 24);
				hpos = (p + 1) & 63;
				if (p == POS_SIG) begin
					if (raw[31:16] != BMP_SIG) pending.push_back(make_err(ERR_SIG));
				end else if (p == POS_WIDTH) begin
					wid = (raw >= 1 && raw <= MAX_WIDTH) ? raw : 0;
				end else if (p == POS_HEIGHT) begin
					tdown = 32'(raw[31]);
					mag = (tdown != 0) ? -raw : raw;
					hgt = (mag >= 1 && mag <= MAX_HEIGHT) ? mag : 0;
				end else if (p == POS_BPP) begin
					if (b != BPP_24) pending.push_back(make_err(ERR_DEPTH));
				end else if (p == POS_COMPR) begin
					if (raw != 0) pending.push_back(make_err(ERR_COMPR));
				end else if (p == POS_END) begin
					if (wid == 0 || hgt == 0) pending.push_back(make_err(ERR_SIZE));
					else begin phase = 1; rcnt = 0; ccnt = 0; chan = 0; end
				end
			end
			1: begin
				if (chan == 0) begin bl = 32'(b); chan = 1; end
				else if (chan == 1) begin gr = 32'(b); chan = 2; end
				else begin
					chan = 0;
					y = 32'((13937 * lin_lut[b] + 46869 * lin_lut[gr] + 4731 * lin_lut[bl]
						+ 32768) >> 16);
					if (y > 65535) y = 65535;
					g = 0;
					for (int k = 0; k < 255; k++) if (enc_lut[k] <= y) g++;
					r = '0;
					r.grey = 8'(g);
					r.glyph = 7'(RAMP_STR[(g * 64) / 255]);
					r.row = (tdown != 0) ? 12'(rcnt) : 12'(hgt - 1 - rcnt);
					r.column = 12'(ccnt);
					if (ccnt + 1 >= wid) begin
						ccnt = 0;
						if (rcnt + 1 >= hgt) begin r.last = 1'b1; phase = 3; end
						else begin
							rcnt++;
							padl = wid & 3;
							if (padl != 0) phase = 2;
						end
					end else ccnt++;
					pending.push_back(r);
				end
			end
			2: begin
				padl = (padl - 1) & 3;
				if (padl == 0) phase = 1;
			end
			default: ;
			endcase
		endfunction

		function void check_result(pixel_res_t got);
			pixel_res_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				$display("%0t: mismatch expected kind=%0d code=%0d grey=%0d glyph=%0d",
					$time, exp_r.kind, exp_r.code, exp_r.grey, exp_r.glyph);
				$display("%0t:          expected row=%0d col=%0d last=%0d",
					$time, exp_r.row, exp_r.column, exp_r.last);
				$display("%0t:          actual   kind=%0d code=%0d grey=%0d glyph=%0d",
					$time, got.kind, got.code, got.grey, got.glyph);
				$display("%0t:          actual   row=%0d col=%0d last=%0d",
					$time, got.row, got.column, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid, m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser, m_axis_tlast;

	bmp24_stream_to_grey_glyph_top u_dut (.*);

	bmp_scoreboard sb;
	int idle_cycles;
	int items_sent;
	logic stall_run;
	logic [7:0] file_bytes[$];

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// receiver: stalls come in runs; some long stretches with no stall at all
	int stall_mode;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
		0: m_axis_tready <= 1'b1;
		1: m_axis_tready <= ($urandom_range(0, 3) != 0);
		default: m_axis_tready <= ($urandom_range(0, 2) == 0);
		endcase
	end

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result({m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3],
					m_axis_tdata[17:11], m_axis_tdata[29:18], m_axis_tdata[41:30],
					m_axis_tlast});
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// send one byte, holding valid until accepted; bursts with random gaps
	task automatic send_byte(logic [7:0] b, logic start);
		if (!stall_run && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b, start);
		items_sent++;
		if ($urandom_range(0, 30) == 0) stall_run = ~stall_run;
	endtask

	task automatic push32(int unsigned v);
		for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
	endtask

	// build a header; fault selects a broken field
	task automatic build_header(int w, int h, int fault);
		file_bytes.delete();
		file_bytes.push_back(fault == ERR_SIG ? 8'($urandom) : 8'h42);
		file_bytes.push_back(8'h4D);
		for (int i = 2; i < 14; i++) file_bytes.push_back(8'($urandom));
		push32(40);
		push32(w);
		push32(h);
		file_bytes.push_back(8'd1);
		file_bytes.push_back(8'd0);
		file_bytes.push_back(fault == ERR_DEPTH ? 8'($urandom_range(0, 23)) : BPP_24);
		file_bytes.push_back(8'($urandom));
		push32(fault == ERR_COMPR ? (32'd1 << $urandom_range(0, 31)) : 0);
		for (int i = 34; i < 54; i++) file_bytes.push_back(8'($urandom));
	endtask

	task automatic add_pixels(int w, int h, int mode);
		for (int r = 0; r < (h < 0 ? -h : h); r++) begin
			for (int c = 0; c < 3 * w; c++)
				case (mode)
				1: file_bytes.push_back(8'h00);
				2: file_bytes.push_back(8'hFF);
				default: file_bytes.push_back(8'($urandom));
				endcase
			for (int p = 0; p < (w & 3); p++) file_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic send_file(int cut);
		int n;
		n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
		for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int w, h, sel;
		sb = new();
		sb.clear_parse();
		for (int k = 0; k < 256; k++) lin_lut[k] = decode_lin(k, 255);
		for (int k = 0; k < 255; k++) enc_lut[k] = decode_lin(2 * k + 1, 510);
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		items_sent = 0;
		stall_run = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no file_start after reset, black/white pixels, top-down, errors
		build_header(1, 1, ERR_NONE);
		add_pixels(1, 1, 1);
		for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], 1'b0);
		build_header(2, -2, ERR_NONE); add_pixels(2, -2, 2); send_file(0);
		build_header(3, 1, ERR_SIG); send_file(0);
		build_header(3, 1, ERR_DEPTH); send_file(0);
		build_header(3, 1, ERR_COMPR); send_file(0);
		build_header(0, 1, ERR_NONE); send_file(0);
		build_header(-1, 1, ERR_NONE); send_file(0);
		build_header(4097, 1, ERR_NONE); send_file(0);
		build_header(1, 4097, ERR_NONE); send_file(0);
		build_header(1, -4097, ERR_NONE); send_file(0);
		build_header(1, 0, ERR_NONE); send_file(0);
		build_header(3, 2, ERR_NONE); add_pixels(3, 2, 0);
		for (int i = 0; i < 5; i++) file_bytes.push_back(8'($urandom));
		send_file(0);
		// extreme coordinates: widest and tallest, cut short by a restart
		build_header(4096, -4096, ERR_NONE); add_pixels(2, 1, 0); send_file(0);
		build_header(1, 4096, ERR_NONE); add_pixels(1, 3, 0); send_file(0);

		// random files: mostly valid, some broken or abandoned mid-way
		while (items_sent < 1550) begin
			sel = $urandom_range(0, 9);
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			if ($urandom_range(0, 1)) h = -h;
			if (sel == 0) begin
				build_header(w, h, $urandom_range(1, 3)); send_file(0);
			end else if (sel == 1) begin
				build_header($urandom, $urandom, ERR_NONE); add_pixels(1, 1, 0);
				send_file(0);
			end else begin
				build_header(w, h, ERR_NONE);
				add_pixels(w, h, 0);
				if ($urandom_range(0, 2) == 0)
					for (int i = 0; i < $urandom_range(1, 6); i++)
						file_bytes.push_back(8'($urandom));
				send_file(sel == 2 ? $urandom_range(1, file_bytes.size()) : 0);
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
sv/bmpgg_pkg.sv
sv/bmp24_stream_to_grey_glyph_top.sv
sim/bmp24_stream_to_grey_glyph_top_tb.sv
